FILE: hw/rtl/lcnc_pkg.sv
`timescale 1ns / 1ps

package lcnc_pkg;

    // binary input and its decimal image
    localparam int NUM_BITS      = 64;
    localparam int NUM_DIGITS    = 20;
    localparam int BCD_W         = 4 * NUM_DIGITS;

    // shift-add-3 conversion: four input bits per pipeline stage
    localparam int BITS_PER_STAGE = 4;
    localparam int DABBLE_STAGES  = NUM_BITS / BITS_PER_STAGE;

    // digit sums are formed in groups of five
    localparam int GROUP_SIZE    = 5;
    localparam int NUM_GROUPS    = NUM_DIGITS / GROUP_SIZE;
    localparam int GROUP_SUM_W   = 6;
    localparam int LUHN_SUM_W    = 8;
    localparam int LUHN_MAX_TENS = 18;
    localparam int LEN_W         = 5;

    // issuer classes
    localparam logic [1:0] CLASS_INVALID   = 2'd0;
    localparam logic [1:0] CLASS_FIFTEEN   = 2'd1;
    localparam logic [1:0] CLASS_SIXTEEN   = 2'd2;
    localparam logic [1:0] CLASS_LEAD_FOUR = 2'd3;

    // lengths and prefix digits used by the class rules
    localparam logic [LEN_W-1:0] LEN_THIRTEEN = 5'd13;
    localparam logic [LEN_W-1:0] LEN_FIFTEEN  = 5'd15;
    localparam logic [LEN_W-1:0] LEN_SIXTEEN  = 5'd16;
    localparam logic [LEN_W-1:0] LEN_MIN_PFX  = 5'd3;

    typedef logic [BCD_W-1:0]    bcd_t;
    typedef logic [NUM_BITS-1:0] bin_t;

    // digit summary handed from the evaluate stage to the classify stage
    typedef struct packed {
        logic [LEN_W-1:0]                        len;
        logic [3:0]                              lead_hi;
        logic [3:0]                              lead_lo;
        logic [NUM_GROUPS-1:0][GROUP_SUM_W-1:0] part_sum;
    } digit_info_t;

endpackage

FILE: hw/rtl/lcnc_dabble_stage.sv
`timescale 1ns / 1ps

module lcnc_dabble_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lcnc_pkg::bin_t       in_bin,
    input  lcnc_pkg::bcd_t       in_bcd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lcnc_pkg::bin_t       out_bin,
    output lcnc_pkg::bcd_t       out_bcd
);

    logic           valid_reg;
    lcnc_pkg::bin_t bin_reg;
    lcnc_pkg::bcd_t bcd_reg;
    lcnc_pkg::bin_t bin_next;
    lcnc_pkg::bcd_t bcd_next;

    // four shift-add-3 steps
    always_comb begin
        bin_next = in_bin;
        bcd_next = in_bcd;
        for (int s = 0; s < lcnc_pkg::BITS_PER_STAGE; s++) begin
            for (int d = 0; d < lcnc_pkg::NUM_DIGITS; d++) begin
                if (bcd_next[4*d +: 4] >= 4'd5) begin
                    bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[lcnc_pkg::BCD_W-2:0], bin_next[lcnc_pkg::NUM_BITS-1]};
            bin_next = {bin_next[lcnc_pkg::NUM_BITS-2:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;
    assign out_bcd   = bcd_reg;

endmodule

FILE: hw/rtl/lcnc_digit_eval.sv
`timescale 1ns / 1ps

module lcnc_digit_eval (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lcnc_pkg::bcd_t        in_bcd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lcnc_pkg::digit_info_t out_info
);

    logic                  valid_reg;
    lcnc_pkg::digit_info_t info_reg;
    lcnc_pkg::digit_info_t info_next;
    logic [3:0]            dig;
    logic [4:0]            dbl;
    logic [3:0]            contrib;

    always_comb begin
        info_next = '0;
        dig       = '0;
        dbl       = '0;
        contrib   = '0;
        for (int i = 0; i < lcnc_pkg::NUM_DIGITS; i++) begin
            dig = in_bcd[4*i +: 4];
            // every second digit from the right is doubled, digits of the double added
            if ((i % 2) == 1) begin
                dbl     = {dig, 1'b0};
                contrib = (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
            end else begin
                contrib = dig;
            end
            info_next.part_sum[i / lcnc_pkg::GROUP_SIZE] =
                info_next.part_sum[i / lcnc_pkg::GROUP_SIZE] +
                lcnc_pkg::GROUP_SUM_W'(contrib);
            if (dig != 4'd0) begin
                info_next.len = lcnc_pkg::LEN_W'(i + 1);
            end
            if (i > 0 && dig != 4'd0) begin
                info_next.lead_hi = dig;
                info_next.lead_lo = in_bcd[4*(i-1) +: 4];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            info_reg <= info_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_info  = info_reg;

endmodule

FILE: hw/rtl/lcnc_classify.sv
`timescale 1ns / 1ps

module lcnc_classify (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lcnc_pkg::digit_info_t in_info,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_class,
    output logic                  out_ok
);

    logic                            valid_reg;
    logic [1:0]                      class_reg;
    logic                            ok_reg;
    logic [1:0]                      class_next;
    logic                            ok_next;
    logic [lcnc_pkg::LUHN_SUM_W-1:0] sum;
    logic                            tens;
    logic                            pfx_fifteen;
    logic                            pfx_sixteen;
    logic                            pfx_four;

    always_comb begin
        sum = '0;
        for (int g = 0; g < lcnc_pkg::NUM_GROUPS; g++) begin
            sum = sum + lcnc_pkg::LUHN_SUM_W'(in_info.part_sum[g]);
        end
        // sum never exceeds 180, so divisibility is a match against the multiples of ten
        tens = 1'b0;
        for (int k = 0; k <= lcnc_pkg::LUHN_MAX_TENS; k++) begin
            if (sum == lcnc_pkg::LUHN_SUM_W'(10 * k)) begin
                tens = 1'b1;
            end
        end
        ok_next = tens && (in_info.len != '0);

        pfx_fifteen = (in_info.len == lcnc_pkg::LEN_FIFTEEN) && (in_info.lead_hi == 4'd3) &&
                      (in_info.lead_lo == 4'd4 || in_info.lead_lo == 4'd7);
        pfx_sixteen = (in_info.len == lcnc_pkg::LEN_SIXTEEN) && (in_info.lead_hi == 4'd5) &&
                      (in_info.lead_lo >= 4'd1) && (in_info.lead_lo <= 4'd5);
        pfx_four    = (in_info.len == lcnc_pkg::LEN_THIRTEEN ||
                       in_info.len == lcnc_pkg::LEN_SIXTEEN) && (in_info.lead_hi == 4'd4);

        class_next = lcnc_pkg::CLASS_INVALID;
        if (ok_next && in_info.len >= lcnc_pkg::LEN_MIN_PFX) begin
            if (pfx_fifteen) begin
                class_next = lcnc_pkg::CLASS_FIFTEEN;
            end else if (pfx_sixteen) begin
                class_next = lcnc_pkg::CLASS_SIXTEEN;
            end else if (pfx_four) begin
                class_next = lcnc_pkg::CLASS_LEAD_FOUR;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            class_reg <= class_next;
            ok_reg    <= ok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_class = class_reg;
    assign out_ok    = ok_reg;

endmodule

FILE: hw/rtl/luhn_card_number_classifier.sv
`timescale 1ns / 1ps
// channel   ports                                       direction
// --------  ------------------------------------------  ---------
// input     s_valid s_ready s_card_number[63:0]          in
// result    m_valid m_ready m_card_class[1:0] m_luhn_ok  out
//
// the result passes 16 conversion stages
// (four binary bits each, shift-add-3) then digit evaluate and classify.
// one item can enter every cycle unless m_ready stalls; each of the 18 stages holds one item.
// aresetn (synchronous, active low) clears all stage valid bits.
// ready runs back combinationally, so a stall on m_ready holds each full stage
// with no empty stage after it in the same cycle, while empty stages still fill.

module luhn_card_number_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_card_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_card_class,
    output logic        m_luhn_ok
);

    localparam int NSTG = lcnc_pkg::DABBLE_STAGES;

    // conversion chain links: index 0 is the input side
    logic           stg_valid [0:NSTG];
    logic           stg_ready [0:NSTG];
    lcnc_pkg::bin_t stg_bin   [0:NSTG];
    lcnc_pkg::bcd_t stg_bcd   [0:NSTG];

    logic                  info_valid;
    logic                  info_ready;
    lcnc_pkg::digit_info_t info;

    assign stg_valid[0] = s_valid;
    assign s_ready      = stg_ready[0];
    assign stg_bin[0]   = s_card_number;
    assign stg_bcd[0]   = '0;

    // binary to decimal, four bits per stage
    for (genvar g = 0; g < NSTG; g++) begin : g_dabble
        lcnc_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_bin    (stg_bin[g]),
            .in_bcd    (stg_bcd[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_bin   (stg_bin[g+1]),
            .out_bcd   (stg_bcd[g+1])
        );
    end

    // digit count, leading pair and partial luhn sums
    lcnc_digit_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[NSTG]),
        .in_ready  (stg_ready[NSTG]),
        .in_bcd    (stg_bcd[NSTG]),
        .out_valid (info_valid),
        .out_ready (info_ready),
        .out_info  (info)
    );

    // final sum, mod-ten check and issuer rules; doubles as output register
    lcnc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (info_valid),
        .in_ready  (info_ready),
        .in_info   (info),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_class (m_card_class),
        .out_ok    (m_luhn_ok)
    );

endmodule
